// ----- hw/rtl/doc_pkg.sv -----
// ----------------------------------------------------------------------------
// doc_pkg: shared types and constants
// Command codes, order machine states, register indexes and stream widths
// of the directional occupancy controller.
// ----------------------------------------------------------------------------
package doc_pkg;

    // Stream payload widths
    localparam int ECHO_W   = 20;
    localparam int CMD_W    = 3;
    localparam int OCC_W    = 8;
    localparam int S_DATA_W = 48;   // 43 payload bits padded to bytes
    localparam int M_DATA_W = 16;   // 12 payload bits padded to bytes

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int THR_W      = 10;
    localparam int TMO_W      = 5;
    localparam int LIMIT_W    = 16; // threshold times 58

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INSIDE_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PENDING_TIMEOUT = 2'd2;

    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RESET = 16'd580;  // 10 cm
    localparam logic [TMO_W-1:0]   INSIDE_TMO_RESET = 5'd5;
    localparam logic [TMO_W-1:0]   PENDING_TMO_RESET = 5'd20;
    localparam logic [TMO_W-1:0]   PENDING_SAT = 5'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE      = 3'd0,
        CMD_ALL_ON    = 3'd1,
        CMD_ALL_OFF   = 3'd2,
        CMD_LIGHT_ON  = 3'd3,
        CMD_LIGHT_OFF = 3'd4,
        CMD_FAN_ON    = 3'd5,
        CMD_FAN_OFF   = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        ORD_EMPTY = 2'd0,   // no trigger pending
        ORD_IN    = 2'd1,   // inside sensor fired first
        ORD_OUT   = 2'd2,   // outside sensor fired first
        ORD_HELD  = 2'd3    // inside then outside at zero occupancy
    } ord_t;

endpackage

// ----- hw/rtl/directional_occupancy_controller.sv -----
// ----------------------------------------------------------------------------
// directional_occupancy_controller: two-sensor room occupancy and drives
// Counts entries and exits from a pair of ultrasonic sensors and drives the
// light and fan from manual commands and occupancy.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per sensor tick, carrying both echo widths in
//   microseconds and a command code. m_ channel: one result per request,
//   carrying the occupancy after the tick, the light and fan drives and the
//   entry and exit flags of that tick.
//   Path: a request accepted into the input stage moves on to the result stage,
//   which drives m_tdata (two registers: input stage, result stage).
//   Throughput: one request per cycle while m_tready is high; the order machine,
//   counter and drive logic settle in the single combinational pass between the two stages.
//   Stall: when m_tready stays low the result holds, the input stage keeps
//   one more request, and s_tready then drops until the result is taken.
//   Reset (aresetn low, synchronous): both stages empty, occupancy zero,
//   drives off, order machine empty, registers back to 10 cm, 5 and 20 ticks.
//   Configuration writes take effect at once; write only while idle.
//   The distance test compares the echo against threshold*58, kept in a
//   register computed at write time, so no divider is needed.
// ----------------------------------------------------------------------------
module directional_occupancy_controller #(
    parameter int COUNT_MAX   = 255,
    parameter int ECHO_MAX_US = 1000000
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request: [19:0] inside_echo_us, [39:20] outside_echo_us, [42:40] command
    input  logic [doc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // result: [7:0] occupancy, [8] light_on, [9] fan_on, [10] entry_event,
    //         [11] exit_event
    output logic [doc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [doc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [doc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import doc_pkg::*;

    localparam int CNT_W = $clog2(COUNT_MAX + 1);
    localparam logic [CNT_W-1:0]  CNT_TOP  = CNT_W'(COUNT_MAX);
    localparam logic [ECHO_W-1:0] ECHO_TOP = ECHO_W'(ECHO_MAX_US);

    // Configuration
    logic [LIMIT_W-1:0] near_limit_reg;
    logic [TMO_W-1:0]   inside_tmo_reg;
    logic [TMO_W-1:0]   pending_tmo_reg;
    logic [LIMIT_W-1:0] thr_times_58;

    // Input stage
    logic              in_valid_reg;
    logic [ECHO_W-1:0] in_inside_reg;
    logic [ECHO_W-1:0] in_outside_reg;
    cmd_t              in_cmd_reg;

    // Block state
    ord_t             ord_reg, ord_next, ord_stepped;
    logic [TMO_W-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             light_reg, light_next;
    logic             fan_reg, fan_next;
    logic             light_mark_reg, light_mark_next;
    logic             fan_mark_reg, fan_mark_next;
    logic             manual_off_reg, manual_off_next;

    // Result stage
    logic             m_valid_reg;
    logic [OCC_W-1:0] occ_reg;
    logic             light_out_reg;
    logic             fan_out_reg;
    logic             entry_reg, entry_next;
    logic             exit_reg, exit_next;

    logic move;
    logic in_near, out_near;
    logic cmd_light, cmd_fan, cmd_lmark, cmd_fmark, cmd_moff;

    // Advance the input stage into the result stage when the result slot frees
    assign move     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || move;

    // threshold*58 = t*32 + t*16 + t*8 + t*2
    assign thr_times_58 = (LIMIT_W'(cfg_wdata) << 5) + (LIMIT_W'(cfg_wdata) << 4)
                        + (LIMIT_W'(cfg_wdata) << 3) + (LIMIT_W'(cfg_wdata) << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_limit_reg  <= NEAR_LIMIT_RESET;
            inside_tmo_reg  <= INSIDE_TMO_RESET;
            pending_tmo_reg <= PENDING_TMO_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEAR_THRESHOLD:  near_limit_reg  <= thr_times_58;
                REG_INSIDE_TIMEOUT:  inside_tmo_reg  <= cfg_wdata[TMO_W-1:0];
                REG_PENDING_TIMEOUT: pending_tmo_reg <= cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: hold the request until it moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_inside_reg  <= s_tdata[ECHO_W-1:0];
            in_outside_reg <= s_tdata[2*ECHO_W-1:ECHO_W];
            in_cmd_reg     <= cmd_t'(s_tdata[2*ECHO_W+CMD_W-1:2*ECHO_W]);
        end
    end

    // Over-range echoes read as zero, which is near like any short echo
    assign in_near  = ((in_inside_reg > ECHO_TOP) ? '0 : in_inside_reg)
                    < ECHO_W'(near_limit_reg);
    assign out_near = ((in_outside_reg > ECHO_TOP) ? '0 : in_outside_reg)
                    < ECHO_W'(near_limit_reg);

    // Manual command, applied before the sensors
    always_comb begin
        cmd_light = light_reg;
        cmd_fan   = fan_reg;
        cmd_lmark = light_mark_reg;
        cmd_fmark = fan_mark_reg;
        cmd_moff  = manual_off_reg;
        case (in_cmd_reg)
            CMD_ALL_ON: begin
                cmd_light = 1'b1;
                cmd_fan   = 1'b1;
                cmd_moff  = 1'b0;
            end
            CMD_ALL_OFF: begin
                cmd_light = 1'b0;
                cmd_fan   = 1'b0;
                cmd_moff  = 1'b1;
            end
            CMD_LIGHT_ON: begin
                cmd_lmark = 1'b1;
                cmd_moff  = 1'b0;
                cmd_light = 1'b1;
            end
            CMD_LIGHT_OFF: begin
                if (!fan_mark_reg) begin
                    cmd_moff = 1'b1;
                end
                cmd_lmark = 1'b0;
                cmd_light = 1'b0;
            end
            CMD_FAN_ON: begin
                cmd_moff  = 1'b0;
                cmd_fmark = 1'b1;
                cmd_fan   = 1'b1;
            end
            CMD_FAN_OFF: begin
                if (!light_mark_reg) begin
                    cmd_moff = 1'b1;
                end
                cmd_fmark = 1'b0;
                cmd_fan   = 1'b0;
            end
            default: ;
        endcase
    end

    // Order machine: next state, then the timeout drops
    always_comb begin
        ord_stepped = ord_reg;
        case (ord_reg)
            ORD_EMPTY: begin
                if (in_near) begin
                    ord_stepped = ORD_IN;
                end else if (out_near) begin
                    ord_stepped = ORD_OUT;
                end
            end
            ORD_IN: begin
                if (out_near) begin
                    ord_stepped = (count_reg != '0) ? ORD_EMPTY : ORD_HELD;
                end
            end
            ORD_OUT: begin
                if (in_near) begin
                    ord_stepped = ORD_EMPTY;
                end
            end
            ORD_HELD: begin
                if (out_near) begin
                    ord_stepped = ORD_EMPTY;
                end
            end
            default: ord_stepped = ORD_EMPTY;
        endcase

        ord_next = ord_stepped;
        if (pending_reg > pending_tmo_reg && ord_stepped != ORD_HELD) begin
            ord_next = ORD_EMPTY;
        end
        if (ord_stepped == ORD_IN && pending_reg > inside_tmo_reg) begin
            ord_next = ORD_EMPTY;
        end
    end

    // Order machine outputs: counter, events, pending age
    always_comb begin
        count_next = count_reg;
        entry_next = 1'b0;
        exit_next  = 1'b0;
        case (ord_reg)
            ORD_IN: begin
                if (out_near && count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                    exit_next  = 1'b1;
                end
            end
            ORD_OUT: begin
                if (in_near) begin
                    if (count_reg < CNT_TOP) begin
                        count_next = count_reg + 1'b1;
                    end
                    entry_next = 1'b1;
                end
            end
            default: ;
        endcase

        if (ord_next == ORD_IN || ord_next == ORD_OUT) begin
            pending_next = (pending_reg == PENDING_SAT) ? pending_reg : pending_reg + 1'b1;
        end else begin
            pending_next = '0;
        end
    end

    // Automatic drive rule on the updated count
    always_comb begin
        light_next      = cmd_light;
        fan_next        = cmd_fan;
        light_mark_next = cmd_lmark;
        fan_mark_next   = cmd_fmark;
        manual_off_next = cmd_moff;
        if (count_next != '0 && !cmd_fmark && !cmd_lmark && !cmd_moff) begin
            light_next      = 1'b1;
            light_mark_next = 1'b1;
            fan_next        = 1'b1;
            fan_mark_next   = 1'b1;
        end else if (count_next == '0) begin
            light_next      = 1'b0;
            light_mark_next = 1'b0;
            fan_next        = 1'b0;
            fan_mark_next   = 1'b0;
        end
    end

    // Commit state only when the request moves into the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ord_reg        <= ORD_EMPTY;
            pending_reg    <= '0;
            count_reg      <= '0;
            light_reg      <= 1'b0;
            fan_reg        <= 1'b0;
            light_mark_reg <= 1'b0;
            fan_mark_reg   <= 1'b0;
            manual_off_reg <= 1'b0;
        end else if (move) begin
            ord_reg        <= ord_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            light_reg      <= light_next;
            fan_reg        <= fan_next;
            light_mark_reg <= light_mark_next;
            fan_mark_reg   <= fan_mark_next;
            manual_off_reg <= manual_off_next;
        end
    end

    // Result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            occ_reg       <= OCC_W'(count_next);
            light_out_reg <= light_next;
            fan_out_reg   <= fan_next;
            entry_reg     <= entry_next;
            exit_reg      <= exit_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, exit_reg, entry_reg, fan_out_reg, light_out_reg, occ_reg};

`ifndef SYNTHESIS
    // An entry and an exit never land on the same tick
    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(entry_reg && exit_reg))
        else $error("entry and exit flagged together");

    // The held order only exists at zero occupancy
    a_held_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ord_reg == ORD_HELD) |-> (count_reg == '0))
        else $error("held order with nonzero occupancy");

    // The pending age runs only while a single trigger is pending
    a_pending_age: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg != '0) |-> (ord_reg == ORD_IN || ord_reg == ORD_OUT))
        else $error("pending age without a pending trigger");

    // Occupancy changes only when a request moves into the result stage
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !move |=> $stable(count_reg))
        else $error("occupancy changed without a request");
`endif

endmodule
